[design/rida_pkg.sv]
// Shared types and constants for the Remote ID advertising parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rida_pkg;

   localparam int MaxPacketDefault = 62;
   localparam int IdCharsDefault   = 20;

   localparam int PosWidth   = 8;
   localparam int CountWidth = 5;

   localparam logic [7:0] AdTypeSvcData = 8'h16;
   localparam logic [7:0] UuidLowByte   = 8'hFA;
   localparam logic [7:0] UuidHighByte  = 8'hFF;
   localparam logic [7:0] AppCodeOdid   = 8'h0D;
   localparam logic [3:0] MsgBasicId    = 4'h0;
   localparam logic [7:0] MinSvcSize    = 8'd4;
   localparam logic [7:0] MinHdrSize    = 8'd5;
   localparam logic [7:0] MinBasicSize  = 8'd26;  // 22-byte message plus 4 header bytes
   localparam logic [7:0] CharLow       = 8'h20;
   localparam logic [7:0] CharHigh      = 8'h7E;
   localparam logic [7:0] CharSubst     = 8'h2E;

   typedef enum logic [3:0] {
      PH_LEN,
      PH_TYPE,
      PH_UUIDLO,
      PH_UUIDHI,
      PH_APP,
      PH_SKIP,
      PH_HEADER,
      PH_UATYPE,
      PH_ID
   } phase_type;

   typedef enum logic {
      KIND_CHAR    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [7:0]            id_char;
      logic                  is_drone;
      logic                  has_basic_id;
      logic [3:0]            aircraft_type;
      logic [CountWidth-1:0] id_length;
   } rsp_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] push_cnt;
   } push_ctl_type;

endpackage

`default_nettype wire

[design/rida_walk.sv]
// AD structure walker: per-packet parse state and result generation.
// Depends on rida_pkg.
`default_nettype none

module rida_walk
   import rida_pkg::*;
#(
   parameter int MAX_PACKET = MaxPacketDefault,
   parameter int ID_CHARS   = IdCharsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] adv_byte,
   input  wire logic [5:0] packet_length,
   input  wire logic       last_byte,
   output logic [1:0]      res_cnt,
   output rsp_type         res0,
   output rsp_type         res1
);

   localparam logic [7:0]            MaxLen  = 8'(MAX_PACKET);
   localparam logic [CountWidth-1:0] IdChars = CountWidth'(ID_CHARS);

   logic [PosWidth-1:0]   pos_ff, pos_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            left_ff, left_in;
   logic [7:0]            size_ff, size_in;
   logic                  drone_ff, drone_in;
   logic                  basic_ff, basic_in;
   logic [3:0]            type_ff, type_in;
   logic [CountWidth-1:0] chars_ff, chars_in;
   logic                  done_ff, done_in;

   // values after this byte, before the end-of-packet clear
   phase_type             step_phase;
   logic [7:0]            step_left;
   logic [7:0]            step_size;
   logic                  step_drone;
   logic                  step_basic;
   logic [3:0]            step_type;
   logic [CountWidth-1:0] step_chars;
   logic                  step_done;
   logic                  char_hit;

   logic [7:0] len8;
   logic [8:0] pos_p1;
   logic [9:0] seg_end;
   logic [7:0] left_dec;
   logic [7:0] char_val;

   assign len8     = ({2'b00, packet_length} > MaxLen) ? MaxLen : {2'b00, packet_length};
   assign pos_p1   = {1'b0, pos_ff} + 9'd1;
   assign seg_end  = {2'b00, pos_ff} + 10'd1 + {2'b00, adv_byte};
   assign left_dec = left_ff - 8'd1;

   // next state
   always_comb begin
      step_phase = phase_ff;
      step_left  = left_ff;
      step_size  = size_ff;
      step_drone = drone_ff;
      step_basic = basic_ff;
      step_type  = type_ff;
      step_chars = chars_ff;
      step_done  = done_ff;
      char_hit   = 1'b0;

      if (!done_ff) begin
         if (phase_ff == PH_LEN) begin
            if (pos_p1 >= {1'b0, len8} || adv_byte == 8'd0 || seg_end > {2'b00, len8}) begin
               step_done = 1'b1;
            end else begin
               step_size  = adv_byte;
               step_left  = adv_byte;
               step_phase = PH_TYPE;
            end
         end else begin
            step_left = left_dec;
            case (phase_ff)
               PH_TYPE: begin
                  step_phase = (adv_byte == AdTypeSvcData && size_ff >= MinSvcSize) ?
                               PH_UUIDLO : PH_SKIP;
               end
               PH_UUIDLO: begin
                  step_phase = (adv_byte == UuidLowByte) ? PH_UUIDHI : PH_SKIP;
               end
               PH_UUIDHI: begin
                  step_phase = (adv_byte == UuidHighByte) ? PH_APP : PH_SKIP;
               end
               PH_APP: begin
                  if (adv_byte == AppCodeOdid) begin
                     step_drone = 1'b1;
                     if (size_ff >= MinHdrSize) begin
                        step_phase = PH_HEADER;
                     end else begin
                        step_done = 1'b1;
                     end
                  end else begin
                     step_phase = PH_SKIP;
                  end
               end
               PH_HEADER: begin
                  if (adv_byte[7:4] == MsgBasicId && size_ff >= MinBasicSize) begin
                     step_phase = PH_UATYPE;
                  end else begin
                     step_done = 1'b1;
                  end
               end
               PH_UATYPE: begin
                  step_type  = adv_byte[7:4];
                  step_basic = 1'b1;
                  step_chars = '0;
                  step_phase = PH_ID;
               end
               PH_ID: begin
                  if (adv_byte == 8'd0) begin
                     step_done = 1'b1;
                  end else begin
                     char_hit   = 1'b1;
                     step_chars = chars_ff + CountWidth'(1);
                     if (step_chars >= IdChars) begin
                        step_done = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (!step_done && step_phase == PH_SKIP && left_dec == 8'd0) begin
               step_phase = PH_LEN;
            end
         end
      end

      if (last_byte) begin
         pos_in   = '0;
         phase_in = PH_LEN;
         left_in  = '0;
         size_in  = '0;
         drone_in = 1'b0;
         basic_in = 1'b0;
         type_in  = '0;
         chars_in = '0;
         done_in  = 1'b0;
      end else begin
         pos_in   = (pos_ff != {PosWidth{1'b1}}) ? pos_ff + PosWidth'(1) : pos_ff;
         phase_in = step_phase;
         left_in  = step_left;
         size_in  = step_size;
         drone_in = step_drone;
         basic_in = step_basic;
         type_in  = step_type;
         chars_in = step_chars;
         done_in  = step_done;
      end
   end

   // results
   always_comb begin
      rsp_type chr;
      rsp_type smry;

      char_val = (adv_byte inside {[CharLow:CharHigh]}) ? adv_byte : CharSubst;

      chr               = '0;
      chr.kind          = KIND_CHAR;
      chr.id_char       = char_val;

      smry               = '0;
      smry.kind          = KIND_SUMMARY;
      smry.is_drone      = step_drone;
      smry.has_basic_id  = step_basic;
      smry.aircraft_type = step_basic ? step_type : 4'd0;
      smry.id_length     = step_chars;

      res0    = char_hit ? chr : smry;
      res1    = smry;
      res_cnt = {1'b0, char_hit} + {1'b0, last_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_LEN;
         left_ff  <= '0;
         size_ff  <= '0;
         drone_ff <= 1'b0;
         basic_ff <= 1'b0;
         type_ff  <= '0;
         chars_ff <= '0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         size_ff  <= size_in;
         drone_ff <= drone_in;
         basic_ff <= basic_in;
         type_ff  <= type_in;
         chars_ff <= chars_in;
         done_ff  <= done_in;
      end
   end

`ifndef SYNTH
   a_chars_bound: assert property (@(posedge clock) disable iff (reset)
      chars_ff <= IdChars)
      else $error("ID character count past limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte |=> pos_ff == '0 && !done_ff && chars_ff == '0)
      else $error("packet state not cleared after last byte");

   a_char_in_basic: assert property (@(posedge clock) disable iff (reset)
      fire && char_hit |-> drone_ff && basic_ff && !done_ff)
      else $error("ID character outside a Basic ID message");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      fire && done_ff && !last_byte |=> done_ff && $stable(chars_ff) && $stable(drone_ff))
      else $error("walk state changed after verdict");
`endif

endmodule

`default_nettype wire

[design/rida_outq.sv]
// Two-entry result queue; head entry drives the response ports.
// Depends on rida_pkg.
`default_nettype none

module rida_outq
   import rida_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire push_ctl_type push,
   input  wire rsp_type      push0,
   input  wire rsp_type      push1,
   output logic [1:0]        count,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);

   rsp_type    s0_ff, s0_in;
   rsp_type    s1_ff, s1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   rsp_type    rem0;
   logic [1:0] rem_cnt;
   logic [1:0] push_cnt;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign push_cnt  = push.fire ? push.push_cnt : 2'd0;
   assign rem0      = pop ? s1_ff : s0_ff;
   assign rem_cnt   = count_ff - {1'b0, pop};

   always_comb begin
      s0_in    = (rem_cnt != 2'd0) ? rem0 : push0;
      case (rem_cnt)
         2'd2:    s1_in = s1_ff;
         2'd1:    s1_in = push0;
         default: s1_in = push1;
      endcase
      count_in = rem_cnt + push_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign count     = count_ff;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = s0_ff;

endmodule

`default_nettype wire

[design/remote_id_advert_parser_top.sv]
// Path: an accepted request is held in the input register, then its results enter the result queue.
// Throughput: one request per cycle while the result queue has room for its results; a request
// giving an ID character and the summary puts both on the response port in turn, via the result queue.
// Reset: synchronous, active high; clears the parse state, input stage and result queue.
// Top level: input register, walker (rida_walk) and result queue (rida_outq); uses rida_pkg.
`default_nettype none

module remote_id_advert_parser_top
   import rida_pkg::*;
#(
   parameter int MAX_PACKET = MaxPacketDefault,
   parameter int ID_CHARS   = IdCharsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_adv_byte,
   input  wire logic [5:0] req_packet_length,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_kind,
   output logic [7:0]      rsp_id_char,
   output logic            rsp_is_drone,
   output logic            rsp_has_basic_id,
   output logic [3:0]      rsp_aircraft_type,
   output logic [4:0]      rsp_id_length
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [5:0] in_plen_ff;
   logic       in_last_ff;

   logic [1:0]   res_cnt;
   rsp_type      res0, res1;
   logic [1:0]   q_count;
   push_ctl_type push;
   rsp_type      head;
   logic         fire;

   // results always fit: queue fill plus this request's results stays within two
   assign fire      = in_valid_ff && (({1'b0, q_count} + {1'b0, res_cnt}) <= 3'd2);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_adv_byte;
         in_plen_ff <= req_packet_length;
         in_last_ff <= req_last_byte;
      end
   end

   rida_walk #(
      .MAX_PACKET (MAX_PACKET),
      .ID_CHARS   (ID_CHARS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .adv_byte      (in_byte_ff),
      .packet_length (in_plen_ff),
      .last_byte     (in_last_ff),
      .res_cnt       (res_cnt),
      .res0          (res0),
      .res1          (res1)
   );

   assign push.fire     = fire;
   assign push.push_cnt = res_cnt;

   rida_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push0     (res0),
      .push1     (res1),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_id_char       = head.id_char;
   assign rsp_is_drone      = head.is_drone;
   assign rsp_has_basic_id  = head.has_basic_id;
   assign rsp_aircraft_type = head.aircraft_type;
   assign rsp_id_length     = head.id_length;

endmodule

`default_nettype wire

[tb/tb_remote_id_advert_parser_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for remote_id_advert_parser_top: streams advertising packets,
// predicts ID characters and end-of-packet summaries, checks them in order.
// Depends on rida_pkg and the design sources only.

module tb_remote_id_advert_parser_top
   import rida_pkg::*;
();

   localparam int CycleLimit = 400000;
   localparam int ItemTarget = 750;

   typedef logic [7:0] byte_q [$];

   typedef struct {
      logic [7:0] b;
      logic [5:0] plen;
      logic       last;
      bit         drain;   // hold this request until all results are back
   } adv_byte_item;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_adv_byte = 8'h00;
   logic [5:0] req_packet_length = 6'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_id_char;
   logic       rsp_is_drone;
   logic       rsp_has_basic_id;
   logic [3:0] rsp_aircraft_type;
   logic [4:0] rsp_id_length;

   adv_byte_item bytes_to_send[$];
   rsp_type      results_due[$];

   int err_count = 0;
   int cycle_count = 0;
   int sent_count = 0;
   int counted = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // parser state as predicted
   int unsigned walk_pos;
   phase_type   walk_ph;
   logic [7:0]  seg_left;
   logic [7:0]  seg_size;
   bit          saw_drone;
   bit          saw_basic;
   logic [3:0]  ua_nibble;
   logic [4:0]  chars_out;
   bit          walk_over;

   remote_id_advert_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adv_byte      (req_adv_byte),
      .req_packet_length (req_packet_length),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_id_char       (rsp_id_char),
      .rsp_is_drone      (rsp_is_drone),
      .rsp_has_basic_id  (rsp_has_basic_id),
      .rsp_aircraft_type (rsp_aircraft_type),
      .rsp_id_length     (rsp_id_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      err_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic void start_packet();
      walk_pos  = 0;
      walk_ph   = PH_LEN;
      seg_left  = 8'd0;
      seg_size  = 8'd0;
      saw_drone = 1'b0;
      saw_basic = 1'b0;
      ua_nibble = 4'd0;
      chars_out = 5'd0;
      walk_over = 1'b0;
   endfunction

   function automatic void parse_advert_byte(input logic [7:0] b, input logic [5:0] plen,
                                             input logic last);
      int unsigned lim;
      rsp_type     r;
      lim = (plen > MaxPacketDefault) ? MaxPacketDefault : plen;
      if (!walk_over) begin
         if (walk_ph == PH_LEN) begin
            if (walk_pos + 1 >= lim || b == 8'd0 || walk_pos + 1 + b > lim) begin
               walk_over = 1'b1;
            end else begin
               seg_size = b;
               seg_left = b;
               walk_ph  = PH_TYPE;
            end
         end else begin
            seg_left = seg_left - 8'd1;
            case (walk_ph)
               PH_TYPE: begin
                  if (b == AdTypeSvcData && seg_size >= MinSvcSize) walk_ph = PH_UUIDLO;
                  else walk_ph = PH_SKIP;
               end
               PH_UUIDLO: begin
                  if (b == UuidLowByte) walk_ph = PH_UUIDHI;
                  else walk_ph = PH_SKIP;
               end
               PH_UUIDHI: begin
                  if (b == UuidHighByte) walk_ph = PH_APP;
                  else walk_ph = PH_SKIP;
               end
               PH_APP: begin
                  if (b == AppCodeOdid) begin
                     saw_drone = 1'b1;
                     if (seg_size >= MinHdrSize) walk_ph = PH_HEADER;
                     else walk_over = 1'b1;
                  end else begin
                     walk_ph = PH_SKIP;
                  end
               end
               PH_HEADER: begin
                  if (b[7:4] == MsgBasicId && seg_size >= MinBasicSize) walk_ph = PH_UATYPE;
                  else walk_over = 1'b1;
               end
               PH_UATYPE: begin
                  ua_nibble = b[7:4];
                  saw_basic = 1'b1;
                  chars_out = 5'd0;
                  walk_ph   = PH_ID;
               end
               PH_ID: begin
                  if (b == 8'd0) begin
                     walk_over = 1'b1;
                  end else begin
                     r = '0;
                     r.kind = KIND_CHAR;
                     r.id_char = (b >= CharLow && b <= CharHigh) ? b : CharSubst;
                     results_due.push_back(r);
                     chars_out = chars_out + 5'd1;
                     if (chars_out >= IdCharsDefault) walk_over = 1'b1;
                  end
               end
               default: ;
            endcase
            if (!walk_over && walk_ph == PH_SKIP && seg_left == 8'd0) walk_ph = PH_LEN;
         end
      end
      if (walk_pos < 255) walk_pos++;
      if (last) begin
         r = '0;
         r.kind = KIND_SUMMARY;
         r.is_drone = saw_drone;
         r.has_basic_id = saw_basic;
         r.aircraft_type = saw_basic ? ua_nibble : 4'd0;
         r.id_length = chars_out;
         results_due.push_back(r);
         start_packet();
      end
   endfunction

   task automatic queue_packet(input byte_q body, input int plen, input int cut,
                               input bit drain, input bit jitter);
      adv_byte_item it;
      for (int i = 0; i < cut; i++) begin
         it.b = (i < body.size()) ? body[i] : 8'($urandom);
         it.plen = 6'(plen);
         // occasional length change in the middle of a packet
         if (jitter && $urandom_range(99) < 3) it.plen = 6'($urandom_range(63));
         it.last = (i == cut - 1);
         it.drain = drain && (i == 0);
         bytes_to_send.push_back(it);
      end
      counted += cut;
   endtask

   function automatic logic [7:0] pick_id_char();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 8'h00;
      if (r < 80) return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] mostly(input logic [7:0] good, input int pct);
      if ($urandom_range(99) < pct) return good;
      return 8'($urandom);
   endfunction

   task automatic make_random_packet(input bit drain);
      byte_q      body;
      logic [7:0] svc[6];
      int         r, n, size, plen, cut;
      r = $urandom_range(99);
      if (r < 15) begin
         n = $urandom_range(1, 64);
         for (int i = 0; i < n; i++) body.push_back(8'($urandom));
         if ($urandom_range(1)) body[0] = 8'($urandom_range(0, 8));
         queue_packet(body, $urandom_range(63), n, drain, 1'b1);
         return;
      end
      if ($urandom_range(1)) begin
         body.push_back(8'h02); body.push_back(8'h01); body.push_back(8'h06);
      end
      if ($urandom_range(99) < 40) begin
         n = $urandom_range(1, 6);
         body.push_back(8'(n));
         for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 85) begin
         r = $urandom_range(99);
         if (r < 75) size = 26;
         else if (r < 85) size = $urandom_range(27, 30);
         else size = $urandom_range(4, 25);
         svc[0] = mostly(AdTypeSvcData, 90);
         svc[1] = mostly(UuidLowByte, 93);
         svc[2] = mostly(UuidHighByte, 93);
         svc[3] = mostly(AppCodeOdid, 90);
         svc[4] = {($urandom_range(99) < 88) ? MsgBasicId : 4'($urandom), 4'($urandom)};
         svc[5] = 8'($urandom);
         body.push_back(8'(size));
         for (int k = 0; k < size; k++) begin
            if (k < 6) body.push_back(svc[k]);
            else if (k < 26) body.push_back(pick_id_char());
            else body.push_back(8'($urandom));
         end
      end
      if ($urandom_range(99) < 30) begin
         n = $urandom_range(1, 6);
         body.push_back(8'(n));
         for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      end
      r = $urandom_range(99);
      if (r < 80) plen = body.size();
      else if (r < 90) plen = $urandom_range(63);
      else plen = body.size() - $urandom_range(1, 3);
      if (plen < 0) plen = 0;
      r = $urandom_range(99);
      if (r < 85) cut = plen;
      else if (r < 93) cut = (plen > 1) ? $urandom_range(1, plen) : 1;
      else cut = plen + $urandom_range(1, 5);
      if (cut < 1) cut = 1;
      queue_packet(body, plen, cut, drain, 1'b1);
   endtask

   always @(posedge clock) begin : cycle_counter
      cycle_count++;
      if (cycle_count % 64 == 0) begin
         req_idle_pct = 25 * $urandom_range(2);
         rsp_idle_pct = 25 * $urandom_range(2);
      end
      if (cycle_count >= CycleLimit) begin
         $display("tb_remote_id_advert_parser_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_requests
      adv_byte_item nxt;
      bit           offer;
      int           gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            parse_advert_byte(req_adv_byte, req_packet_length, req_last_byte);
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (bytes_to_send.size() > 0) begin
               if (bytes_to_send[0].drain && results_due.size() != 0) begin
                  offer = 1'b0;
               end else if (bytes_to_send.size() >= 120 &&
                            $urandom_range(99) < req_idle_pct) begin
                  gap_left = $urandom_range(0, 3);
               end else begin
                  nxt = bytes_to_send.pop_front();
                  offer = 1'b1;
               end
            end
            if (offer) begin
               req_valid         <= 1'b1;
               req_adv_byte      <= nxt.b;
               req_packet_length <= nxt.plen;
               req_last_byte     <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_ready
      int hold_left;
      bit long_hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else if (!long_hold_done && sent_count >= 300) begin
         // long back-pressure so the block fills and stalls its input
         long_hold_done = 1'b1;
         hold_left = 60;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (bytes_to_send.size() >= 120 && $urandom_range(99) < rsp_idle_pct) begin
         hold_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            want = results_due.pop_front();
            check_field("kind", rsp_kind, want.kind);
            check_field("id_char", rsp_id_char, want.id_char);
            check_field("is_drone", rsp_is_drone, want.is_drone);
            check_field("has_basic_id", rsp_has_basic_id, want.has_basic_id);
            check_field("aircraft_type", rsp_aircraft_type, want.aircraft_type);
            check_field("id_length", rsp_id_length, want.id_length);
         end
      end
   end

   initial begin
      int pkt_no;
      start_packet();
      // directed: corner cases of the walk
      queue_packet('{8'hFF}, 0, 1, 1'b0, 1'b0);
      queue_packet('{8'h00, 8'h12, 8'h34}, 3, 3, 1'b0, 1'b0);
      queue_packet('{8'h05, 8'h01, 8'h02}, 3, 3, 1'b0, 1'b0);
      queue_packet('{8'h01, 8'h09, 8'h01}, 3, 3, 1'b0, 1'b0);
      queue_packet('{8'h04, 8'h16, 8'hFA, 8'hFF, 8'h0D}, 5, 5, 1'b0, 1'b0);
      queue_packet('{8'h05, 8'h16, 8'hFA, 8'hFF, 8'h0D, 8'h1F}, 6, 6, 1'b0, 1'b0);
      queue_packet('{8'h02, 8'h01, 8'h06, 8'h03}, 63, 4, 1'b0, 1'b0);
      pkt_no = 0;
      while (counted < ItemTarget) begin
         // one very long stream to saturate the byte position
         if (pkt_no == 10) queue_packet('{8'h02, 8'h01, 8'h06}, 62, 270, 1'b0, 1'b0);
         make_random_packet(pkt_no % 25 == 5);
         pkt_no++;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (bytes_to_send.size() > 0 || req_valid) @(posedge clock);
      while (results_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_remote_id_advert_parser_top: clean");
      end else begin
         $display("tb_remote_id_advert_parser_top: errors");
      end
      $finish;
   end

endmodule
